### design/dep_pkg.sv
// Shared types and constants for the double-ended priority queue.
// No dependencies; every other design file imports this package.
package dep_pkg;

    localparam int CAPACITY = 1024;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [CNT_W-1:0] t_count;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_EXT_MIN = 2'd1,
        OP_EXT_MAX = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    // Command broadcast to every cell of the sorted chain
    typedef enum logic [2:0] {
        CMD_HOLD = 3'd0,
        CMD_INS  = 3'd1,
        CMD_SHL  = 3'd2,
        CMD_DROP = 3'd3,
        CMD_CLR  = 3'd4
    } t_cmd;

    typedef struct packed {
        logic               vld;
        logic signed [31:0] val;
    } t_entry;

endpackage

### design/dep_if.sv
// Valid/ready channels for request and result items.
// Depends on dep_pkg.
interface dep_req_if;
    import dep_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] value;
    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface dep_rsp_if;
    import dep_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic [10:0]        count;
    modport source (output valid, output status, output out_value, output min_value,
                    output max_value, output count, input ready);
    modport sink   (input valid, input status, input out_value, input min_value,
                    input max_value, input count, output ready);
endinterface

### design/dep_cell.sv
// One cell of the sorted chain: holds one entry, ascending from cell 0.
// Depends on dep_pkg.
module dep_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dep_pkg::t_cmd      i_cmd,
    input  logic signed [31:0] i_value,
    input  dep_pkg::t_entry    i_left,
    input  dep_pkg::t_entry    i_right,
    output dep_pkg::t_entry    o_entry
);
    import dep_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_left_gt;
    logic   w_own_gt;

    // Pick the next entry from the neighbors and the new value
    always_comb begin
        w_left_gt = i_left.vld && (i_left.val > i_value);
        w_own_gt  = !r_entry.vld || (r_entry.val > i_value);
        n_entry   = r_entry;
        unique case (i_cmd)
            CMD_INS: begin
                if (w_left_gt) begin
                    n_entry = i_left;
                end else if (w_own_gt && i_left.vld) begin
                    n_entry.vld = 1'b1;
                    n_entry.val = i_value;
                end
            end
            CMD_SHL:  n_entry = i_right;
            CMD_DROP: n_entry.vld = r_entry.vld && i_right.vld;
            CMD_CLR:  n_entry.vld = 1'b0;
            default:  n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.vld <= 1'b0;
        end else begin
            r_entry.vld <= n_entry.vld;
        end
        r_entry.val <= n_entry.val;
    end

    assign o_entry = r_entry;

endmodule

### design/double_ended_priority_queue.sv
// Double-ended priority queue: a chain of CAPACITY cells kept sorted ascending.
// The result is valid in S_OUT, after S_APPLY and S_READ; one request at a time,
// so a new request is taken only after the result has been taken on o_out.ready.
// The cell chain shifts at most one place per operation; the max read is one OR tree.
// Reset (i_rst_n low, synchronous) empties the queue and idles the handshake.
module double_ended_priority_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    dep_req_if.sink   i_in,
    dep_rsp_if.source o_out
);
    import dep_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_APPLY = 4'b0010,
        S_READ  = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    t_op                r_op;
    logic signed [31:0] r_value;
    t_count             r_count;
    t_status            r_status;
    logic signed [31:0] r_out_value;
    logic signed [31:0] r_min;
    logic signed [31:0] r_max;
    t_cmd               w_cmd;
    t_entry             w_cell [CAPACITY];
    logic signed [31:0] w_max;
    t_entry             w_edge_left;
    t_entry             w_edge_right;

    assign w_edge_left.vld  = 1'b1;
    assign w_edge_left.val  = 32'sh8000_0000;
    assign w_edge_right.vld = 1'b0;
    assign w_edge_right.val = '0;

    // Build the chain of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_l, w_r;
        if (g == 0) begin : g_first
            assign w_l = w_edge_left;
        end else begin : g_mid_l
            assign w_l = w_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_r = w_edge_right;
        end else begin : g_mid_r
            assign w_r = w_cell[g+1];
        end
        dep_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_value (r_value),
            .i_left  (w_l),
            .i_right (w_r),
            .o_entry (w_cell[g])
        );
    end

    // Decode the chain command for the apply cycle
    always_comb begin
        w_cmd = CMD_HOLD;
        if (r_state == S_APPLY) begin
            unique case (r_op)
                OP_INSERT:  w_cmd = (r_count < t_count'(CAPACITY)) ? CMD_INS : CMD_HOLD;
                OP_EXT_MIN: w_cmd = (r_count != '0) ? CMD_SHL : CMD_HOLD;
                OP_EXT_MAX: w_cmd = (r_count != '0) ? CMD_DROP : CMD_HOLD;
                OP_CLEAR:   w_cmd = CMD_CLR;
                default:    w_cmd = CMD_HOLD;
            endcase
        end
    end

    // Select the last valid cell as the maximum
    always_comb begin
        w_max = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_cell[i].vld && ((i == CAPACITY - 1) || !w_cell[(i + 1) % CAPACITY].vld)) begin
                w_max = w_max | w_cell[i].val;
            end
        end
    end

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in.valid) n_state = S_APPLY;
            S_APPLY: n_state = S_READ;
            S_READ:  n_state = S_OUT;
            S_OUT:   if (o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_min   <= '0;
            r_max   <= '0;
        end else begin
            r_state <= n_state;
            // Update count, status and extracted value
            if (r_state == S_APPLY) begin
                r_status    <= ST_OK;
                r_out_value <= '0;
                unique case (r_op)
                    OP_INSERT: begin
                        if (r_count < t_count'(CAPACITY)) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_status <= ST_FULL;
                        end
                    end
                    OP_EXT_MIN, OP_EXT_MAX: begin
                        if (r_count != '0) begin
                            r_count     <= r_count - 1'b1;
                            r_out_value <= (r_op == OP_EXT_MIN) ? r_min : r_max;
                        end else begin
                            r_status <= ST_EMPTY;
                        end
                    end
                    OP_CLEAR: r_count <= '0;
                    default:  r_count <= r_count;
                endcase
            end
            // Capture both ends of the chain
            if (r_state == S_READ) begin
                r_min <= w_cell[0].vld ? w_cell[0].val : 32'sd0;
                r_max <= w_max;
            end
        end
        // Hold the accepted request
        if (r_state == S_IDLE && i_in.valid) begin
            r_op    <= t_op'(i_in.op);
            r_value <= i_in.value;
        end
    end

    assign i_in.ready      = i_rst_n && (r_state == S_IDLE);
    assign o_out.valid     = (r_state == S_OUT);
    assign o_out.status    = r_status;
    assign o_out.out_value = r_out_value;
    assign o_out.min_value = r_min;
    assign o_out.max_value = r_max;
    assign o_out.count     = r_count;

endmodule
